// ===== rtl/mbw_pkg.sv =====
// Shared constants and types for the moving-box world bounding box core.
package mbw_pkg;

  // Default number format: signed Q8.8
  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  // Frame registers are three packed 16-bit parts
  localparam int REG_W   = 48;
  localparam int APB_DW  = 64;
  localparam int APB_AW  = 6;
  localparam int IDX_W   = 3;

  // Register indexes (byte address = 8 * index)
  localparam logic [IDX_W-1:0] RegOrigin = 3'd0;
  localparam logic [IDX_W-1:0] RegSpeed  = 3'd1;
  localparam logic [IDX_W-1:0] RegAxisA  = 3'd2;
  localparam logic [IDX_W-1:0] RegAxisB  = 3'd3;
  localparam logic [IDX_W-1:0] RegAxisC  = 3'd4;

  // Reset frame: identity axes, no offset, no motion
  localparam logic [REG_W-1:0] OriginRst = 48'd0;
  localparam logic [REG_W-1:0] SpeedRst  = 48'd0;
  localparam logic [REG_W-1:0] AxisARst  = 48'd256;
  localparam logic [REG_W-1:0] AxisBRst  = 48'd16777216;
  localparam logic [REG_W-1:0] AxisCRst  = 48'd1099511627776;

  // Per-stage load strobes from the pipeline control
  typedef struct packed {
    logic s1;  // products
    logic s2;  // pairwise min/max
    logic s3;  // sums
    logic s4;  // saturate and output
  } mbw_ld_t;

endpackage

// ===== rtl/moving_box_world_aabb_core.sv =====
// Four register stages from an accepted input beat to its result beat (products, min/max,
// sums, saturate/output register), one lane per world axis.
// Throughput: one beat per cycle unless stalled; stages load independently, so bubbles
// close up under an output stall and the input is only stalled when every stage is full.
// Reset: asynchronous, active low; clears the pipeline valids and loads the identity
// frame (zero origin and speed, unit axes). No clearing pass.
module moving_box_world_aabb_core #(
  parameter int COORD_WIDTH = mbw_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = mbw_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mbw_pkg::APB_AW-1:0]        paddr,
  input  logic [mbw_pkg::APB_DW-1:0]        pwdata,
  output logic [mbw_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]     box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0]     box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0]     box_min_z_i,
  input  logic signed [COORD_WIDTH-1:0]     box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0]     box_max_y_i,
  input  logic signed [COORD_WIDTH-1:0]     box_max_z_i,
  input  logic signed [COORD_WIDTH-1:0]     time_start_i,
  input  logic signed [COORD_WIDTH-1:0]     time_end_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COORD_WIDTH-1:0]     world_min_x_o,
  output logic signed [COORD_WIDTH-1:0]     world_min_y_o,
  output logic signed [COORD_WIDTH-1:0]     world_min_z_o,
  output logic signed [COORD_WIDTH-1:0]     world_max_x_o,
  output logic signed [COORD_WIDTH-1:0]     world_max_y_o,
  output logic signed [COORD_WIDTH-1:0]     world_max_z_o,
  output logic signed [COORD_WIDTH-1:0]     time_start_out_o,
  output logic signed [COORD_WIDTH-1:0]     time_end_out_o,
  output logic                              overflow_flag_o
);

  localparam int PW    = 2 * COORD_WIDTH;
  localparam int ACC_W = ((PW > COORD_WIDTH + FRAC_BITS) ? PW : COORD_WIDTH + FRAC_BITS) + 3;
  localparam int RW    = mbw_pkg::REG_W;

  logic [RW-1:0] origin_q, speed_q, axis_a_q, axis_b_q, axis_c_q;
  logic [mbw_pkg::IDX_W-1:0] reg_idx;
  logic cfg_wr;

  // Register file: write on the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[mbw_pkg::APB_AW-1:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= mbw_pkg::OriginRst;
      speed_q  <= mbw_pkg::SpeedRst;
      axis_a_q <= mbw_pkg::AxisARst;
      axis_b_q <= mbw_pkg::AxisBRst;
      axis_c_q <= mbw_pkg::AxisCRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mbw_pkg::RegOrigin: origin_q <= pwdata[RW-1:0];
        mbw_pkg::RegSpeed:  speed_q  <= pwdata[RW-1:0];
        mbw_pkg::RegAxisA:  axis_a_q <= pwdata[RW-1:0];
        mbw_pkg::RegAxisB:  axis_b_q <= pwdata[RW-1:0];
        mbw_pkg::RegAxisC:  axis_c_q <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_idx)
      mbw_pkg::RegOrigin: prdata = mbw_pkg::APB_DW'(origin_q);
      mbw_pkg::RegSpeed:  prdata = mbw_pkg::APB_DW'(speed_q);
      mbw_pkg::RegAxisA:  prdata = mbw_pkg::APB_DW'(axis_a_q);
      mbw_pkg::RegAxisB:  prdata = mbw_pkg::APB_DW'(axis_b_q);
      mbw_pkg::RegAxisC:  prdata = mbw_pkg::APB_DW'(axis_c_q);
      default:            prdata = '0;
    endcase
  end

  // Pipeline control: each stage moves when it is empty or the next one moves
  logic v1_q, v2_q, v3_q, vout_q;
  logic en1, en2, en3, en4;
  mbw_pkg::mbw_ld_t ld;

  assign en4 = !vout_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign ld.s1 = en1 & in_valid_i;
  assign ld.s2 = en2 & v1_q;
  assign ld.s3 = en3 & v2_q;
  assign ld.s4 = en4 & v3_q;

  assign in_stall_o  = !en1;
  assign out_valid_o = vout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (en1) v1_q   <= in_valid_i;
      if (en2) v2_q   <= v1_q;
      if (en3) v3_q   <= v2_q;
      if (en4) vout_q <= v3_q;
    end
  end

  // Time interval rides alongside the lanes
  logic signed [COORD_WIDTH-1:0] t0_q [3];
  logic signed [COORD_WIDTH-1:0] t1_q [3];

  always_ff @(posedge clk_i) begin
    if (ld.s1) begin
      t0_q[0] <= time_start_i;
      t1_q[0] <= time_end_i;
    end
    if (ld.s2) begin
      t0_q[1] <= t0_q[0];
      t1_q[1] <= t1_q[0];
    end
    if (ld.s3) begin
      t0_q[2] <= t0_q[1];
      t1_q[2] <= t1_q[1];
    end
  end

  // Axis lanes; register part k sits at bits k*COORD_WIDTH
  logic signed [ACC_W-1:0] lane_lo [3];
  logic signed [ACC_W-1:0] lane_hi [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [COORD_WIDTH-1:0] org_k, spd_k, ca_k, cb_k, cc_k;

    assign org_k = COORD_WIDTH'(64'(origin_q) >> (k * COORD_WIDTH));
    assign spd_k = COORD_WIDTH'(64'(speed_q)  >> (k * COORD_WIDTH));
    assign ca_k  = COORD_WIDTH'(64'(axis_a_q) >> (k * COORD_WIDTH));
    assign cb_k  = COORD_WIDTH'(64'(axis_b_q) >> (k * COORD_WIDTH));
    assign cc_k  = COORD_WIDTH'(64'(axis_c_q) >> (k * COORD_WIDTH));

    mbw_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .ld_i     (ld),
      .org_i    (org_k),
      .spd_i    (spd_k),
      .comp_a_i (ca_k),
      .comp_b_i (cb_k),
      .comp_c_i (cc_k),
      .min_x_i  (box_min_x_i),
      .min_y_i  (box_min_y_i),
      .min_z_i  (box_min_z_i),
      .max_x_i  (box_max_x_i),
      .max_y_i  (box_max_y_i),
      .max_z_i  (box_max_z_i),
      .t0_i     (time_start_i),
      .t1_i     (time_end_i),
      .lo_o     (lane_lo[k]),
      .hi_o     (lane_hi[k])
    );
  end

  // Merge and output register
  logic signed [COORD_WIDTH-1:0] wmin [3];
  logic signed [COORD_WIDTH-1:0] wmax [3];

  mbw_merge #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_merge (
    .clk_i  (clk_i),
    .ld_i   (ld),
    .lo_i   (lane_lo),
    .hi_i   (lane_hi),
    .t0_i   (t0_q[2]),
    .t1_i   (t1_q[2]),
    .wmin_o (wmin),
    .wmax_o (wmax),
    .t0_o   (time_start_out_o),
    .t1_o   (time_end_out_o),
    .ovf_o  (overflow_flag_o)
  );

  assign world_min_x_o = wmin[0];
  assign world_min_y_o = wmin[1];
  assign world_min_z_o = wmin[2];
  assign world_max_x_o = wmax[0];
  assign world_max_y_o = wmax[1];
  assign world_max_z_o = wmax[2];

endmodule

// ===== rtl/mbw_lane.sv =====
// One axis lane: products, per-term extremes and the summed world range.
module mbw_lane #(
  parameter int COORD_WIDTH = mbw_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = mbw_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  mbw_pkg::mbw_ld_t                       ld_i,
  input  logic signed [COORD_WIDTH-1:0]          org_i,
  input  logic signed [COORD_WIDTH-1:0]          spd_i,
  input  logic signed [COORD_WIDTH-1:0]          comp_a_i,
  input  logic signed [COORD_WIDTH-1:0]          comp_b_i,
  input  logic signed [COORD_WIDTH-1:0]          comp_c_i,
  input  logic signed [COORD_WIDTH-1:0]          min_x_i,
  input  logic signed [COORD_WIDTH-1:0]          min_y_i,
  input  logic signed [COORD_WIDTH-1:0]          min_z_i,
  input  logic signed [COORD_WIDTH-1:0]          max_x_i,
  input  logic signed [COORD_WIDTH-1:0]          max_y_i,
  input  logic signed [COORD_WIDTH-1:0]          max_z_i,
  input  logic signed [COORD_WIDTH-1:0]          t0_i,
  input  logic signed [COORD_WIDTH-1:0]          t1_i,
  output logic signed [((2*COORD_WIDTH > COORD_WIDTH+FRAC_BITS) ?
                        2*COORD_WIDTH : COORD_WIDTH+FRAC_BITS)+2:0] lo_o,
  output logic signed [((2*COORD_WIDTH > COORD_WIDTH+FRAC_BITS) ?
                        2*COORD_WIDTH : COORD_WIDTH+FRAC_BITS)+2:0] hi_o
);

  localparam int PW    = 2 * COORD_WIDTH;
  localparam int ACC_W = ((PW > COORD_WIDTH + FRAC_BITS) ? PW : COORD_WIDTH + FRAC_BITS) + 3;

  // Term order: t, x, y, z; each with low and high choice
  localparam int NT = 4;

  logic signed [PW-1:0] prod_lo_q [NT];
  logic signed [PW-1:0] prod_hi_q [NT];
  logic signed [PW-1:0] ext_lo_q  [NT];
  logic signed [PW-1:0] ext_hi_q  [NT];
  logic signed [ACC_W-1:0] org_s;
  logic signed [ACC_W-1:0] lo_d, hi_d;

  // Stage 1: eight products, one per term choice
  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      prod_lo_q[0] <= spd_i * t0_i;
      prod_hi_q[0] <= spd_i * t1_i;
      prod_lo_q[1] <= comp_a_i * min_x_i;
      prod_hi_q[1] <= comp_a_i * max_x_i;
      prod_lo_q[2] <= comp_b_i * min_y_i;
      prod_hi_q[2] <= comp_b_i * max_y_i;
      prod_lo_q[3] <= comp_c_i * min_z_i;
      prod_hi_q[3] <= comp_c_i * max_z_i;
    end
  end

  // Stage 2: the terms are independent, so the corner hull splits per term
  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      for (int i = 0; i < NT; i++) begin
        if (prod_lo_q[i] < prod_hi_q[i]) begin
          ext_lo_q[i] <= prod_lo_q[i];
          ext_hi_q[i] <= prod_hi_q[i];
        end else begin
          ext_lo_q[i] <= prod_hi_q[i];
          ext_hi_q[i] <= prod_lo_q[i];
        end
      end
    end
  end

  // Stage 3: origin scaled to product format plus the extreme terms
  assign org_s = ACC_W'(org_i) <<< FRAC_BITS;

  always_comb begin
    lo_d = org_s;
    hi_d = org_s;
    for (int i = 0; i < NT; i++) begin
      lo_d = lo_d + ACC_W'(ext_lo_q[i]);
      hi_d = hi_d + ACC_W'(ext_hi_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      lo_o <= lo_d;
      hi_o <= hi_d;
    end
  end

endmodule

// ===== rtl/mbw_merge.sv =====
// Merge of the three lanes: drop fraction, saturate, flag and output register.
module mbw_merge #(
  parameter int COORD_WIDTH = mbw_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = mbw_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  mbw_pkg::mbw_ld_t                       ld_i,
  input  logic signed [((2*COORD_WIDTH > COORD_WIDTH+FRAC_BITS) ?
                        2*COORD_WIDTH : COORD_WIDTH+FRAC_BITS)+2:0] lo_i [3],
  input  logic signed [((2*COORD_WIDTH > COORD_WIDTH+FRAC_BITS) ?
                        2*COORD_WIDTH : COORD_WIDTH+FRAC_BITS)+2:0] hi_i [3],
  input  logic signed [COORD_WIDTH-1:0]          t0_i,
  input  logic signed [COORD_WIDTH-1:0]          t1_i,
  output logic signed [COORD_WIDTH-1:0]          wmin_o [3],
  output logic signed [COORD_WIDTH-1:0]          wmax_o [3],
  output logic signed [COORD_WIDTH-1:0]          t0_o,
  output logic signed [COORD_WIDTH-1:0]          t1_o,
  output logic                                   ovf_o
);

  localparam int PW    = 2 * COORD_WIDTH;
  localparam int ACC_W = ((PW > COORD_WIDTH + FRAC_BITS) ? PW : COORD_WIDTH + FRAC_BITS) + 3;
  localparam logic signed [ACC_W-1:0] SatHi = ACC_W'((64'(1) << (COORD_WIDTH - 1)) - 64'(1));
  localparam logic signed [ACC_W-1:0] SatLo = -SatHi - ACC_W'(1);

  logic signed [ACC_W-1:0]       lo_f [3];
  logic signed [ACC_W-1:0]       hi_f [3];
  logic signed [COORD_WIDTH-1:0] wmin_d [3];
  logic signed [COORD_WIDTH-1:0] wmax_d [3];
  logic                          ovf_d;

  // Floor by arithmetic shift, then clamp to the coordinate range
  always_comb begin
    ovf_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lo_f[k] = lo_i[k] >>> FRAC_BITS;
      hi_f[k] = hi_i[k] >>> FRAC_BITS;
      if (lo_f[k] > SatHi) begin
        wmin_d[k] = COORD_WIDTH'(SatHi);
        ovf_d     = 1'b1;
      end else if (lo_f[k] < SatLo) begin
        wmin_d[k] = COORD_WIDTH'(SatLo);
        ovf_d     = 1'b1;
      end else begin
        wmin_d[k] = COORD_WIDTH'(lo_f[k]);
      end
      if (hi_f[k] > SatHi) begin
        wmax_d[k] = COORD_WIDTH'(SatHi);
        ovf_d     = 1'b1;
      end else if (hi_f[k] < SatLo) begin
        wmax_d[k] = COORD_WIDTH'(SatLo);
        ovf_d     = 1'b1;
      end else begin
        wmax_d[k] = COORD_WIDTH'(hi_f[k]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      wmin_o <= wmin_d;
      wmax_o <= wmax_d;
      t0_o   <= t0_i;
      t1_o   <= t1_i;
      ovf_o  <= ovf_d;
    end
  end

endmodule

// ===== rtl/mbw_checker.sv =====
// Port-level checks for the moving-box world bounding box core, with its bind.
module mbw_checker #(
  parameter int COORD_WIDTH = mbw_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          pready,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [COORD_WIDTH-1:0] world_min_x_o,
  input logic signed [COORD_WIDTH-1:0] world_max_x_o,
  input logic signed [COORD_WIDTH-1:0] world_min_y_o,
  input logic signed [COORD_WIDTH-1:0] world_max_y_o
);

  // Reset empties the pipeline: no result beat on the edge after a reset edge
  a_no_beat_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result beat shown after reset");

  // A free output never back-pressures the input
  a_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with the output free");

  // X and y hull bounds stay ordered after flooring and clamping
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (world_min_x_o <= world_max_x_o) && (world_min_y_o <= world_max_y_o))
    else $error("world lower bound above upper bound");

  // A stalled result beat stays presented and unchanged
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(world_min_x_o)
                                   && $stable(world_max_x_o))
    else $error("stalled result beat changed");

  // Register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind moving_box_world_aabb_core mbw_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_mbw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .world_min_x_o (world_min_x_o),
  .world_max_x_o (world_max_x_o),
  .world_min_y_o (world_min_y_o),
  .world_max_y_o (world_max_y_o)
);

// ===== sim/moving_box_world_aabb_core_tb.sv =====
// Self-checking bench for the world AABB core: directed and random boxes scored against a behavioural predictor.
`timescale 1ns / 1ps

module moving_box_world_aabb_core_tb;

  localparam int CW               = mbw_pkg::COORD_WIDTH_DEF;
  localparam int FRAC             = mbw_pkg::FRAC_BITS_DEF;
  localparam int NUM_REGS         = 5;
  localparam int RESET_CYCLES     = 2;
  localparam int SETTLE_CYCLES    = 12;
  localparam int RANDOM_PER_FRAME = 268;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam longint Q_MAX        = 32767;
  localparam longint Q_MIN        = -32768;

  // writes to these must leave the frame untouched
  localparam logic [mbw_pkg::IDX_W-1:0] RegUnmapped    = 3'd5;
  localparam logic [mbw_pkg::IDX_W-1:0] RegUnmappedTop = 3'd7;

  // [0..2] lower xyz, [3..5] upper xyz, [6] interval start, [7] interval end
  typedef logic [7:0][CW-1:0] coord_set_t;

  typedef struct packed {
    coord_set_t coord;
    logic       ovf;
  } hull_t;

  typedef enum int {
    FrSmall, FrMaxParts, FrMinParts, FrZero, FrAllOnes, FrWide, FrSmallStray, FrCount
  } frame_kind_e;

  typedef enum int {StallNone, StallHalf, StallHeavy, StallSolid} stall_mode_e;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // configuration port
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [mbw_pkg::APB_AW-1:0]    paddr   = '0;
  logic [mbw_pkg::APB_DW-1:0]    pwdata  = '0;
  logic [mbw_pkg::APB_DW-1:0]    prdata;
  logic                          pready;

  // input channel
  logic                  in_valid = 1'b0;
  logic                  in_stall_o;
  coord_set_t            box_q = '0;
  logic signed [CW-1:0]  box_min_x_i, box_min_y_i, box_min_z_i;
  logic signed [CW-1:0]  box_max_x_i, box_max_y_i, box_max_z_i;
  logic signed [CW-1:0]  time_start_i, time_end_i;
  logic                  in_valid_i;

  assign in_valid_i   = in_valid;
  assign box_min_x_i  = box_q[0];
  assign box_min_y_i  = box_q[1];
  assign box_min_z_i  = box_q[2];
  assign box_max_x_i  = box_q[3];
  assign box_max_y_i  = box_q[4];
  assign box_max_z_i  = box_q[5];
  assign time_start_i = box_q[6];
  assign time_end_i   = box_q[7];

  // output channel
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [CW-1:0]  world_min_x_o, world_min_y_o, world_min_z_o;
  logic signed [CW-1:0]  world_max_x_o, world_max_y_o, world_max_z_o;
  logic signed [CW-1:0]  time_start_out_o, time_end_out_o;
  logic                  overflow_flag_o;

  moving_box_world_aabb_core dut (.*);

  // frame as the predictor sees it
  logic [mbw_pkg::REG_W-1:0] frame_reg [NUM_REGS] = '{
    mbw_pkg::OriginRst, mbw_pkg::SpeedRst, mbw_pkg::AxisARst, mbw_pkg::AxisBRst,
    mbw_pkg::AxisCRst
  };

  string out_name [8] = '{"world_min_x", "world_min_y", "world_min_z", "world_max_x",
                          "world_max_y", "world_max_z", "time_start_out", "time_end_out"};
  string reg_name [NUM_REGS] = '{"frame_origin", "frame_speed", "axis_vector_a",
                                 "axis_vector_b", "axis_vector_c"};

  coord_set_t pending_boxes [$];
  hull_t      hull_q [$];
  int         errors         = 0;
  int         boxes_checked  = 0;
  int         saturated_seen = 0;
  int         frames_used    = 0;
  int         idle_cycles    = 0;

  function automatic longint sx(logic [CW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint part(logic [mbw_pkg::REG_W-1:0] r, int ax);
    return sx(r[ax*CW +: CW]);
  endfunction

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic logic [mbw_pkg::REG_W-1:0] pack_xyz(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  // hull of all eight corners at both ends of the interval, per world axis
  function automatic hull_t predict_hull(coord_set_t b);
    hull_t  h;
    longint lo;
    longint hi;
    longint acc;
    h       = '0;
    h.coord[6] = b[6];
    h.coord[7] = b[7];
    for (int ax = 0; ax < 3; ax++) begin
      lo = 0;
      hi = 0;
      for (int ti = 0; ti < 2; ti++) begin
        for (int c = 0; c < 8; c++) begin
          acc = (part(frame_reg[mbw_pkg::RegOrigin], ax) <<< FRAC)
              + part(frame_reg[mbw_pkg::RegSpeed], ax) * sx(b[6+ti]);
          for (int j = 0; j < 3; j++) begin
            acc += part(frame_reg[mbw_pkg::RegAxisA + j], ax) * sx(c[j] ? b[3+j] : b[j]);
          end
          if ((ti == 0 && c == 0) || acc < lo) lo = acc;
          if ((ti == 0 && c == 0) || acc > hi) hi = acc;
        end
      end
      // arithmetic shift floors, matching truncation toward minus infinity
      lo = lo >>> FRAC;
      hi = hi >>> FRAC;
      if (lo != clamp_q(lo) || hi != clamp_q(hi)) h.ovf = 1'b1;
      h.coord[ax]   = CW'(clamp_q(lo));
      h.coord[3+ax] = CW'(clamp_q(hi));
    end
    return h;
  endfunction

  function automatic logic [CW-1:0] edge_value();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // mix of full-range, small, well-ordered and corner-value boxes
  function automatic coord_set_t rand_box();
    coord_set_t b;
    b = '0;
    case ($urandom_range(0, 3))
      0: for (int k = 0; k < 8; k++) b[k] = 16'($urandom);
      1: for (int k = 0; k < 8; k++) b[k] = 16'(int'($urandom_range(0, 2048)) - 1024);
      2: begin
        for (int j = 0; j < 3; j++) begin
          b[j]   = 16'(int'($urandom_range(0, 4096)) - 2048);
          b[3+j] = b[j] + 16'($urandom_range(0, 1024));
        end
        b[6] = 16'(int'($urandom_range(0, 1024)) - 512);
        b[7] = b[6] + 16'($urandom_range(0, 512));
      end
      default: for (int k = 0; k < 8; k++) b[k] = edge_value();
    endcase
    return b;
  endfunction

  function automatic logic [mbw_pkg::REG_W-1:0] rand_frame_word(bit narrow);
    if (narrow)
      return pack_xyz(int'($urandom_range(0, 1024)) - 512, int'($urandom_range(0, 1024)) - 512,
                      int'($urandom_range(0, 1024)) - 512);
    return mbw_pkg::REG_W'({$urandom, $urandom});
  endfunction

  // APB write: setup then access, register lands on the access edge
  task automatic apb_write(input logic [mbw_pkg::IDX_W-1:0] idx,
                           input logic [mbw_pkg::REG_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mbw_pkg::APB_AW'(idx) << 3;
    pwdata  <= mbw_pkg::APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < NUM_REGS) frame_reg[idx] = val;
  endtask

  task automatic apb_check(input logic [mbw_pkg::IDX_W-1:0] idx);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= mbw_pkg::APB_AW'(idx) << 3;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[mbw_pkg::REG_W-1:0] !== frame_reg[idx]) begin
      $error("%s: expected %h, got %h", reg_name[idx], frame_reg[idx],
             prdata[mbw_pkg::REG_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_frame(input logic [mbw_pkg::REG_W-1:0] origin, speed, va, vb, vc,
                           input bit stray);
    apb_write(mbw_pkg::RegOrigin, origin);
    apb_write(mbw_pkg::RegSpeed, speed);
    apb_write(mbw_pkg::RegAxisA, va);
    apb_write(mbw_pkg::RegAxisB, vb);
    apb_write(mbw_pkg::RegAxisC, vc);
    if (stray) begin
      apb_write(RegUnmapped, rand_frame_word(1'b0));
      apb_write(RegUnmappedTop, rand_frame_word(1'b0));
    end
    for (int i = 0; i < NUM_REGS; i++) apb_check(mbw_pkg::IDX_W'(i));
    frames_used++;
  endtask

  // extremes, inverted box and interval, sub-unit negatives
  task automatic queue_directed();
    coord_set_t b;
    b = '0;                                     pending_boxes.push_back(b);
    b = {16'd256, 16'd0, 16'd256, 16'd256, 16'd256, 16'd0, 16'd0, 16'd0};
    pending_boxes.push_back(b);
    b = {8{16'h7FFF}};                          pending_boxes.push_back(b);
    b = {8{16'h8000}};                          pending_boxes.push_back(b);
    b = {16'h7FFF, 16'h8000, {3{16'h7FFF}}, {3{16'h8000}}};
    pending_boxes.push_back(b);
    // lower above upper, start after end
    b = {-16'sd256, 16'd256, {3{16'h8000}}, {3{16'h7FFF}}};
    pending_boxes.push_back(b);
    b = {-16'sd512, 16'd512, 16'd300, 16'd200, 16'd100, -16'sd300, -16'sd200, -16'sd100};
    pending_boxes.push_back(b);
    b = {8{16'hFFFF}};                          pending_boxes.push_back(b);
    b = {-16'sd1, 16'd1, 16'd257, -16'sd255, 16'd255, -16'sd256, 16'd1, -16'sd1};
    pending_boxes.push_back(b);
    b = {16'h8000, 16'h7FFF, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h8000};
    pending_boxes.push_back(b);
  endtask

  task automatic settle();
    while (pending_boxes.size() != 0 || in_valid || hull_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // driver: bursts of beats with random gaps, payload held while stalled
  int burst_left = 8;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    bit fired;
    fired = 1'b0;
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        hull_q.push_back(predict_hull(box_q));
        fired = 1'b1;
      end
      if (!in_valid || fired) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_boxes.size() != 0) begin
          box_q    <= pending_boxes.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: scores each result beat and drives its own stall pattern
  stall_mode_e stall_mode = StallNone;
  int          stall_run  = 0;

  always @(posedge clk_i) begin
    hull_t      want;
    coord_set_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {time_end_out_o, time_start_out_o, world_max_z_o, world_max_y_o,
               world_max_x_o, world_min_z_o, world_min_y_o, world_min_x_o};
        if (hull_q.size() == 0) begin
          $error("result beat with no box outstanding");
          errors++;
        end else begin
          want = hull_q.pop_front();
          boxes_checked++;
          if (want.ovf) saturated_seen++;
          for (int k = 0; k < 8; k++) begin
            if (got[k] !== want.coord[k]) begin
              $error("%s: expected %0d, got %0d", out_name[k], $signed(want.coord[k]),
                     $signed(got[k]));
              errors++;
            end
          end
          if (overflow_flag_o !== want.ovf) begin
            $error("overflow_flag: expected %0b, got %0b", want.ovf, overflow_flag_o);
            errors++;
          end
        end
      end
      if (stall_run <= 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_run  = (stall_mode == StallSolid) ? $urandom_range(1, 16)
                                                : $urandom_range(8, 64);
      end
      stall_run--;
      case (stall_mode)
        StallNone:  out_stall_i <= 1'b0;
        StallHalf:  out_stall_i <= 1'($urandom_range(0, 1));
        StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:    out_stall_i <= 1'b1;
      endcase
    end
  end

  // watchdog: cycles without any beat or register access
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog expired with %0d results outstanding", hull_q.size());
    $display("[moving_box_world_aabb_core] ERROR");
    $finish;
  end

  // sequence: reset frame, a moving rotated frame, then a sweep of frame settings
  initial begin
    frame_kind_e fk;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    settle();

    set_frame(pack_xyz(384, -512, 768), pack_xyz(128, -256, 64), pack_xyz(0, 256, 0),
              pack_xyz(-256, 0, 0), pack_xyz(0, 0, 512), 1'b0);
    queue_directed();
    settle();

    for (int k = 0; k < FrCount; k++) begin
      fk = frame_kind_e'(k);
      case (fk)
        FrMaxParts: set_frame({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                              {3{16'h7FFF}}, 1'b0);
        FrMinParts: set_frame({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                              {3{16'h8000}}, 1'b0);
        FrZero:     set_frame('0, '0, '0, '0, '0, 1'b0);
        FrAllOnes:  set_frame('1, '1, '1, '1, '1, 1'b0);
        FrWide:     set_frame(rand_frame_word(1'b0), rand_frame_word(1'b0),
                              rand_frame_word(1'b0), rand_frame_word(1'b0),
                              rand_frame_word(1'b0), 1'b0);
        default:    set_frame(rand_frame_word(1'b1), rand_frame_word(1'b1),
                              rand_frame_word(1'b1), rand_frame_word(1'b1),
                              rand_frame_word(1'b1), fk == FrSmallStray);
      endcase
      for (int n = 0; n < RANDOM_PER_FRAME; n++) pending_boxes.push_back(rand_box());
      settle();
    end

    $display("Scored %0d boxes under the reset frame and %0d written frames.",
             boxes_checked, frames_used);
    $display("%0d results saturated; %0d mismatches.", saturated_seen, errors);
    if (errors == 0 && hull_q.size() == 0) begin
      $display("[moving_box_world_aabb_core] OK");
    end else begin
      $display("[moving_box_world_aabb_core] ERROR");
    end
    $finish;
  end

endmodule

// ===== moving_box_world_aabb_core.f =====
rtl/mbw_pkg.sv
rtl/mbw_lane.sv
rtl/mbw_merge.sv
rtl/moving_box_world_aabb_core.sv
rtl/mbw_checker.sv
sim/moving_box_world_aabb_core_tb.sv
